// ----- design/mwo_pkg.sv -----
// ============================================================================
// mwo_pkg: shared types and constants of the multiwave oscillator
// Queue entry layout, divider request/response, and fixed-point constants.
// ============================================================================
package mwo_pkg;

    localparam int SAMPLE_RATE_HZ_DEF  = 44100;
    localparam int SINE_TABLE_BITS_DEF = 10;

    localparam int FREQ_W  = 24;
    localparam int COUNT_W = 32;
    localparam int WAVE_W  = 2;
    localparam int SAMP_W  = 16;

    // divider operand widths
    localparam int DIV_N_W = 48;
    localparam int DIV_D_W = 32;

    // queue depth between front and back
    localparam int QDEPTH = 2;

    // Q30 constants of the sine polynomial
    localparam logic [30:0] Q30_ONE     = 31'd1073741824;
    localparam logic [30:0] Q30_HALF_PI = 31'd1686629713;

    typedef enum logic [WAVE_W-1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_SAWTOOTH = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_SINE     = 2'd3
    } wave_t;

    typedef struct packed {
        wave_t               wave;
        logic                zero;
        logic [FREQ_W-1:0]   freq;
        logic [COUNT_W-1:0]  count;
    } entry_t;

    typedef struct packed {
        logic                start;
        logic [DIV_N_W-1:0]  dividend;
        logic [DIV_D_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_N_W-1:0]  quot;
        logic [DIV_D_W-1:0]  rem;
    } div_rsp_t;

    // Horner divisors of the sine polynomial as reciprocals, innermost first.
    // For every 32-bit n, floor(n / d) = (n * ceil(2^s / d)) >> s
    // with s = 32 + ceil(log2(d)).
    function automatic logic [32:0] horner_recip(input logic [2:0] idx);
        logic [32:0] m;
        begin
            case (idx)
                3'd0:    m = 33'd7048151461;   // divide by 156
                3'd1:    m = 33'd4997780127;   // divide by 110
                3'd2:    m = 33'd7635497416;   // divide by 72
                3'd3:    m = 33'd6544712071;   // divide by 42
                3'd4:    m = 33'd6871947674;   // divide by 20
                3'd5:    m = 33'd5726623062;   // divide by 6
                default: m = 33'd0;
            endcase
            return m;
        end
    endfunction

    // Right shift that goes with each reciprocal
    function automatic logic [5:0] horner_shift(input logic [2:0] idx);
        logic [5:0] s;
        begin
            case (idx)
                3'd0:    s = 6'd40;
                3'd1:    s = 6'd39;
                3'd2:    s = 6'd39;
                3'd3:    s = 6'd38;
                3'd4:    s = 6'd37;
                3'd5:    s = 6'd35;
                default: s = 6'd0;
            endcase
            return s;
        end
    endfunction

endpackage

// ----- design/mwo_div.sv -----
// ============================================================================
// mwo_div: shared restoring divider
// One quotient bit per cycle; a done pulse marks quotient and remainder valid.
// ============================================================================
module mwo_div (
    input  logic              clk,
    input  logic              rst_n,
    input  mwo_pkg::div_req_t req,
    output mwo_pkg::div_rsp_t rsp
);
    import mwo_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] dsr_reg, dsr_next;
    logic [DIV_D_W:0]   trial;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    // trial subtract of one step
    always_comb
    begin
        trial = {rem_reg, quo_reg[DIV_N_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = (trial >= {1'b0, dsr_reg});
    end

    // load on start, shift one bit each busy cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_N_W-2:0], ge};
            rem_next = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_N_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- design/mwo_front.sv -----
// ============================================================================
// mwo_front: input side of the oscillator
// Holds the waveform register, accepts beats and flags the zero cases.
// ============================================================================
module mwo_front #(
    parameter int SAMPLE_RATE_HZ = mwo_pkg::SAMPLE_RATE_HZ_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [55:0]           s_tdata,
    output logic                  push_valid,
    input  logic                  push_ready,
    output mwo_pkg::entry_t       push_data
);
    import mwo_pkg::*;

    localparam logic [31:0] RATE_Q8 = 32'(SAMPLE_RATE_HZ * 256);

    wave_t             wave_reg;
    logic [FREQ_W-1:0] freq;
    logic [COUNT_W-1:0] count;

    // write the waveform register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wave_reg <= WAVE_SQUARE;
        else if (cfg_we)
            wave_reg <= wave_t'(cfg_wdata);
    end

    assign freq  = s_tdata[FREQ_W-1:0];
    assign count = s_tdata[FREQ_W+COUNT_W-1:FREQ_W];

    // classify: zero frequency, zero index or zero period
    always_comb
    begin
        push_data.wave  = wave_reg;
        push_data.freq  = freq;
        push_data.count = count;
        push_data.zero  = (freq == '0) || (count == '0) || ({8'd0, freq} > RATE_Q8);
    end

    assign push_valid = s_tvalid;
    assign s_tready   = push_ready;

endmodule

// ----- design/mwo_queue.sv -----
// ============================================================================
// mwo_queue: short FIFO between front and back
// Decouples beat acceptance from the long arithmetic of the back end.
// ============================================================================
module mwo_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  mwo_pkg::entry_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output mwo_pkg::entry_t pop_data
);
    import mwo_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    entry_t             mem [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    // store entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ----- design/mwo_back.sv -----
// ============================================================================
// mwo_back: arithmetic sequencer of the oscillator
// Period, phase and waveform through the shared divider; sine by polynomial.
// ============================================================================
module mwo_back #(
    parameter int SAMPLE_RATE_HZ  = mwo_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int SINE_TABLE_BITS = mwo_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  mwo_pkg::entry_t   pop_data,
    output mwo_pkg::div_req_t div_req,
    input  mwo_pkg::div_rsp_t div_rsp,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata
);
    import mwo_pkg::*;

    localparam int B     = SINE_TABLE_BITS;
    localparam int PER_W = $clog2(SAMPLE_RATE_HZ * 256 + 1);
    localparam logic [DIV_N_W-1:0] RATE_Q8 = DIV_N_W'(SAMPLE_RATE_HZ * 256);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_PER  = 10'b0000000010,
        S_MOD  = 10'b0000000100,
        S_WAV  = 10'b0000001000,
        S_SX   = 10'b0000010000,
        S_SX2  = 10'b0000100000,
        S_TMUL = 10'b0001000000,
        S_TDIV = 10'b0010000000,
        S_SFIN = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } state_t;

    state_t              state_reg, state_next;
    entry_t              ent_reg, ent_next;
    logic [PER_W-1:0]    period_reg, period_next;
    logic [PER_W-1:0]    r_reg, r_next;
    logic [B:0]          k_reg, k_next;
    logic                neg_reg, neg_next;
    logic [30:0]         x_reg, x_next;
    logic [31:0]         x2_reg, x2_next;
    logic [30:0]         t_reg, t_next;
    logic [31:0]         n_reg, n_next;
    logic [2:0]          iter_reg, iter_next;
    logic [SAMP_W-1:0]   res_reg, res_next;
    logic                out_valid_reg;
    logic [SAMP_W-1:0]   out_data_reg;
    logic                out_free;
    logic                out_load;

    logic [PER_W:0]      r2;
    logic                first_half;
    logic [B+1:0]        idx;
    logic [B:0]          k_sel;
    logic [B+31:0]       prod_x;
    logic [61:0]         prod_x2;
    logic [62:0]         prod_t;
    logic [64:0]         prod_q;
    logic [30:0]         q_horner;
    logic [61:0]         prod_s;
    logic [32:0]         s_round;
    logic [17:0]         s_val;
    logic [17:0]         tri_val;
    logic [SAMP_W-1:0]   sine_mag;

    assign out_free  = !out_valid_reg || m_tready;
    assign pop_ready = (state_reg == S_IDLE);
    assign r2         = {r_reg, 1'b0};
    assign first_half = (r2 < {1'b0, period_reg});

    // multipliers, each feeding a register
    assign prod_x  = Q30_HALF_PI * k_reg;
    assign prod_x2 = x_reg * x_reg;
    assign prod_t  = x2_reg * t_reg;
    assign prod_s  = x_reg * t_reg;

    // divide one Horner term by its constant through the reciprocal
    assign prod_q   = n_reg * horner_recip(iter_reg);
    assign q_horner = 31'(prod_q >> horner_shift(iter_reg));

    // round and clamp the sine magnitude
    always_comb
    begin
        s_round  = {1'b0, prod_s[61:30]} + 33'd16384;
        s_val    = 18'(s_round[32:15]);
        sine_mag = (s_val > 18'd32767) ? 16'd32767 : s_val[15:0];
    end

    assign idx   = div_rsp.quot[B+1:0];
    assign k_sel = idx[0 +: B] == '0 && idx[B] ? {1'b1, {B{1'b0}}}
                 : (idx[B] ? (B+1)'({1'b1, {B{1'b0}}} - {1'b0, idx[B-1:0]})
                           : {1'b0, idx[B-1:0]});
    assign tri_val = 18'd98304 - {1'b0, div_rsp.quot[16:0]};

    // sequence one item through the divider and multipliers
    always_comb
    begin
        state_next  = state_reg;
        ent_next    = ent_reg;
        period_next = period_reg;
        r_next      = r_reg;
        k_next      = k_reg;
        neg_next    = neg_reg;
        x_next      = x_reg;
        x2_next     = x2_reg;
        t_next      = t_reg;
        n_next      = n_reg;
        iter_next   = iter_reg;
        res_next    = res_reg;
        out_load    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = RATE_Q8;
        div_req.divisor  = DIV_D_W'(pop_data.freq);
        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    ent_next = pop_data;
                    if (pop_data.zero)
                    begin
                        res_next   = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_PER;
                    end
                end
            end
            S_PER:
            begin
                div_req.dividend = DIV_N_W'(ent_reg.count);
                div_req.divisor  = DIV_D_W'(div_rsp.quot[PER_W-1:0]);
                if (div_rsp.done)
                begin
                    period_next   = div_rsp.quot[PER_W-1:0];
                    div_req.start = 1'b1;
                    state_next    = S_MOD;
                end
            end
            S_MOD:
            begin
                div_req.divisor = DIV_D_W'(period_reg);
                case (ent_reg.wave)
                    WAVE_SAWTOOTH: div_req.dividend =
                        DIV_N_W'({div_rsp.rem[PER_W-1:0], 16'd0});
                    WAVE_TRIANGLE: div_req.dividend =
                        DIV_N_W'({div_rsp.rem[PER_W-1:0], 17'd0});
                    default: div_req.dividend =
                        DIV_N_W'({div_rsp.rem[PER_W-1:0], {(B+2){1'b0}}});
                endcase
                if (div_rsp.done)
                begin
                    r_next = div_rsp.rem[PER_W-1:0];
                    if (ent_reg.wave == WAVE_SQUARE)
                    begin
                        res_next = ({div_rsp.rem[PER_W-1:0], 1'b0} < {1'b0, period_reg})
                                 ? 16'h7FFF : 16'h8000;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_WAV;
                    end
                end
            end
            S_WAV:
            begin
                if (div_rsp.done)
                begin
                    case (ent_reg.wave)
                        WAVE_SAWTOOTH:
                        begin
                            res_next   = {~div_rsp.quot[15], div_rsp.quot[14:0]};
                            state_next = S_OUT;
                        end
                        WAVE_TRIANGLE:
                        begin
                            if (first_half)
                                res_next = {~div_rsp.quot[15], div_rsp.quot[14:0]};
                            else if (tri_val == 18'd32768)
                                res_next = 16'h7FFF;
                            else
                                res_next = tri_val[15:0];
                            state_next = S_OUT;
                        end
                        default:
                        begin
                            k_next     = k_sel;
                            neg_next   = idx[B+1];
                            state_next = S_SX;
                        end
                    endcase
                end
            end
            S_SX:
            begin
                x_next     = prod_x[B+30:B];
                state_next = S_SX2;
            end
            S_SX2:
            begin
                x2_next    = prod_x2[61:30];
                t_next     = Q30_ONE;
                iter_next  = '0;
                state_next = S_TMUL;
            end
            S_TMUL:
            begin
                n_next     = prod_t[61:30];
                state_next = S_TDIV;
            end
            S_TDIV:
            begin
                t_next     = Q30_ONE - q_horner;
                iter_next  = iter_reg + 1'b1;
                state_next = (iter_reg == 3'd5) ? S_SFIN : S_TMUL;
            end
            S_SFIN:
            begin
                res_next   = neg_reg ? 16'(-sine_mag) : sine_mag;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // hold payload
    always_ff @(posedge clk)
    begin
        ent_reg    <= ent_next;
        period_reg <= period_next;
        r_reg      <= r_next;
        k_reg      <= k_next;
        neg_reg    <= neg_next;
        x_reg      <= x_next;
        x2_reg     <= x2_next;
        t_reg      <= t_next;
        n_reg      <= n_next;
        res_reg    <= res_next;
        if (out_load)
            out_data_reg <= res_reg;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_PER || state_reg == S_MOD ||
                          state_reg == S_WAV))
        else $error("divider finished while no division was pending");
    a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD && div_rsp.done) |-> (div_rsp.rem < DIV_D_W'(period_reg)))
        else $error("phase offset not below the period");
    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD) |-> (period_reg != '0))
        else $error("zero period reached the phase division");
    a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TMUL || state_reg == S_TDIV) |-> (iter_reg <= 3'd5))
        else $error("polynomial step count overrun");
`endif

endmodule

// ----- design/multiwave_oscillator.sv -----
// ============================================================================
// multiwave_oscillator: square, sawtooth, triangle and sine test-tone source
// One signed Q1.15 sample per input beat of frequency and sample index.
// ============================================================================
// Each beat takes a front-end queue slot at once; the back end then works on
// it with one shared restoring divider that yields one quotient bit a cycle.
// The back end settles a zero case (zero frequency, zero index or a frequency
// above the sample rate) without the divider, a square sample with two
// divisions, sawtooth and triangle with three, and a sine with three
// divisions and then a six-step polynomial whose constant divisions are
// reciprocal multiplies. The divider sets the throughput; a two-beat queue
// lets input beats arrive while a sample is computed and the output register
// waits for ready.
module multiwave_oscillator #(
    parameter int SAMPLE_RATE_HZ  = mwo_pkg::SAMPLE_RATE_HZ_DEF,
    parameter int SINE_TABLE_BITS = mwo_pkg::SINE_TABLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,     // waveform
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,       // frequency [23:0], sample_count [55:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata        // sample_value [15:0]
);
    import mwo_pkg::*;

    logic     push_valid, push_ready;
    entry_t   push_data;
    logic     pop_valid, pop_ready;
    entry_t   pop_data;
    div_req_t div_req;
    div_rsp_t div_rsp;

    mwo_front #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mwo_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mwo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mwo_back #(
        .SAMPLE_RATE_HZ  (SAMPLE_RATE_HZ),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- tb/testbench.sv -----
// ============================================================================
// testbench: self-checking bench for the multiwave oscillator
// Drives frequency/sample-index beats over the stream slave port and checks
// every output sample against a local bit-exact predictor for all four
// waveforms, under random idling on both sides and a long output stall.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mwo_pkg::*;

    localparam int RATE_HZ    = 44100;
    localparam int TABLE_BITS = 10;
    localparam int WDOG_LIMIT = 20000;
    localparam int TAIL_WAIT  = 600;
    localparam int SEG_ITEMS  = 140;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;      // frequency [23:0], sample_count [55:24]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // sample_value [15:0]

    wave_t       cur_wave;
    logic [15:0] sample_queue[$];
    int          err_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          hold_cycles;
    int          quiet_cycles;
    int          samples_checked;
    int          zero_items;

    multiwave_oscillator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Quarter-wave sine entry: truncated Q30 Horner polynomial, rounded to Q15
    function automatic longint unsigned quarter_sine_q15(input longint unsigned k);
        longint unsigned divs[6];
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        divs = '{156, 110, 72, 42, 20, 6};
        x  = (64'd1686629713 * k) >> TABLE_BITS;
        x2 = (x * x) >> 30;
        t  = 64'd1073741824;
        for (int i = 0; i < 6; i++)
            t = 64'd1073741824 - ((x2 * t) >> 30) / divs[i];
        s = (x * t) >> 30;
        s = (s + (64'd1 << 14)) >> 15;
        if (s > 32767)
            s = 32767;
        return s;
    endfunction

    // Expected Q1.15 sample for one tone beat
    function automatic logic [15:0] tone_sample(input wave_t w, input logic [23:0] freq,
                                                input logic [31:0] cnt);
        longint unsigned period;
        longint unsigned r;
        longint unsigned t;
        longint unsigned idx;
        longint unsigned k;
        longint          v;
        v = 0;
        if (freq != 0 && cnt != 0)
        begin
            period = (64'd256 * RATE_HZ) / freq;
            if (period != 0)
            begin
                r = cnt % period;
                case (w)
                    WAVE_SQUARE:
                        v = (2 * r < period) ? 32767 : -32768;
                    WAVE_SAWTOOTH:
                        v = longint'((r << 16) / period) - 32768;
                    WAVE_TRIANGLE:
                    begin
                        t = (r << 17) / period;
                        v = (2 * r < period) ? longint'(t) - 32768 : 98304 - longint'(t);
                        if (v > 32767)
                            v = 32767;
                    end
                    default:
                    begin
                        idx = (r << (TABLE_BITS + 2)) / period;
                        k   = idx & ((64'd1 << TABLE_BITS) - 1);
                        if (idx[TABLE_BITS])
                            k = (64'd1 << TABLE_BITS) - k;
                        v = longint'(quarter_sine_q15(k));
                        if (idx[TABLE_BITS+1])
                            v = -v;
                    end
                endcase
            end
        end
        return v[15:0];
    endfunction

    // Offer one beat, with random idle cycles first; return once accepted
    task automatic send_tone(input logic [23:0] freq, input logic [31:0] cnt);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cnt, freq};
        do
            @(posedge clk);
        while (!s_tready);
        sample_queue.push_back(tone_sample(cur_wave, freq, cnt));
        if (freq == 0 || cnt == 0 || freq > 24'd11289600)
            zero_items++;
    endtask

    // Wait until every expected sample is out
    task automatic drain_samples();
        s_tvalid <= 1'b0;
        while (sample_queue.size() != 0)
            @(posedge clk);
    endtask

    // Write the waveform register while the block is idle
    task automatic set_waveform(input wave_t w);
        drain_samples();
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_wave  = w;
    endtask

    // Random frequency: mostly audible periods, some outside the valid band
    function automatic logic [23:0] rand_freq();
        case ($urandom_range(9))
            0, 1:    return 24'($urandom_range(24'hFFFFFF));
            2, 3, 4: return 24'($urandom_range(11289600, 1));
            5, 6:    return 24'($urandom_range(4096, 1));
            7:       return 24'($urandom_range(256, 1));
            8:       return 24'($urandom_range(11289602, 11289598));
            default: return ($urandom_range(9) == 0) ? 24'd0
                                                      : 24'($urandom_range(65535, 1));
        endcase
    endfunction

    function automatic logic [31:0] rand_count();
        case ($urandom_range(9))
            0:       return 32'd0;
            1, 2:    return $urandom_range(100000);
            default: return $urandom();
        endcase
    endfunction

    // Extremes, zero cases, period edges and the triangle peak per waveform
    task automatic test_directed();
        for (int w = 0; w < 4; w++)
        begin
            set_waveform(wave_t'(w));
            send_tone(24'd0, 32'd5);
            send_tone(24'd256, 32'd0);
            send_tone(24'd256, 32'd22050);
            send_tone(24'd11289601, 32'd7);
            send_tone(24'd11289600, 32'hFFFFFFFF);
            send_tone(24'd1, 32'hFFFFFFFF);
        end
    endtask

    // Random beats over each waveform at the current idle mix
    task automatic test_random_waves();
        for (int w = 0; w < 4; w++)
        begin
            set_waveform(wave_t'(w));
            for (int i = 0; i < SEG_ITEMS; i++)
                send_tone(rand_freq(), rand_count());
        end
    endtask

    // Stall the output long enough that the input queue fills and backs up
    task automatic test_backpressure();
        set_waveform(WAVE_SQUARE);
        tx_idle_pct = 0;
        hold_cycles = 3000;
        for (int i = 0; i < 12; i++)
            send_tone(rand_freq(), rand_count());
    endtask

    // Output side: random ready, with an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Check each output beat against the oldest expected sample
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (sample_queue.size() == 0)
            begin
                $display("%0t: unexpected sample, expected none, actual %0d",
                         $time, $signed(m_tdata));
                err_count++;
            end
            else
            begin
                if (m_tdata !== sample_queue[0])
                begin
                    $display("%0t: sample_value mismatch, expected %0d, actual %0d",
                             $time, $signed(sample_queue[0]), $signed(m_tdata));
                    err_count++;
                end
                void'(sample_queue.pop_front());
                samples_checked++;
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WDOG_LIMIT);
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cur_wave     = WAVE_SQUARE;
        err_count    = 0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_cycles  = 0;
        quiet_cycles = 0;
        samples_checked = 0;
        zero_items   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        tx_idle_pct = 26;
        rx_idle_pct = 57;
        test_random_waves();
        tx_idle_pct = 57;
        rx_idle_pct = 26;
        test_random_waves();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_waves();
        test_backpressure();

        drain_samples();
        repeat (TAIL_WAIT) @(posedge clk);
        $display("Checked %0d samples over square, sawtooth, triangle and sine;", samples_checked);
        $display("%0d were zero cases, plus a long output stall with a full queue.", zero_items);
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
